FILE: src/pss_pkg.sv
package pss_pkg;

  localparam int DEPTH      = 16;
  localparam int ITEM_WIDTH = 32;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // field widths of the channels
  localparam int MODE_W = 3;
  localparam int POS_W  = 5;
  localparam int VAL_W  = 32;
  localparam int FIDX_W = 4;
  localparam int RCNT_W = 5;
  localparam int ICNT_W = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT_AT     = 3'd0,
    MODE_SORTED_INSERT = 3'd1,
    MODE_ERASE_AT      = 3'd2,
    MODE_REMOVE_ALL    = 3'd3,
    MODE_GET           = 3'd4,
    MODE_SET           = 3'd5,
    MODE_FIND          = 3'd6
  } mode_t;

endpackage

FILE: src/pss_if.sv
interface pss_in_if;
  import pss_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [POS_W-1:0]  position;
  logic [VAL_W-1:0]  item_value;

  modport source (output valid, output mode, output position, output item_value, input ready);
  modport sink   (input valid, input mode, input position, input item_value, output ready);
endinterface

interface pss_out_if;
  import pss_pkg::*;

  logic              valid;
  logic              ready;
  logic              ok;
  logic [VAL_W-1:0]  read_item;
  logic [FIDX_W-1:0] found_index;
  logic [RCNT_W-1:0] removed_count;
  logic [ICNT_W-1:0] item_count;

  modport source (output valid, output ok, output read_item, output found_index,
                  output removed_count, output item_count, input ready);
  modport sink   (input valid, input ok, input read_item, input found_index,
                  input removed_count, input item_count, output ready);
endinterface

FILE: src/positional_sequence_store.sv
// channel  | dir | beat payload
// in_ch    | in  | mode, position, item_value
// out_ch   | out | ok, read_item, found_index, removed_count, item_count
//
// one operation at a time; a beat is taken only while the sequencer is idle
// an operation walks up to 16 slots in ST_RUN, then loads its result in ST_FIN,
// which waits for a free output register; the next beat is taken back in ST_IDLE
// one shared slot read port and one write port
// rst_n is synchronous: count and control clear, slot contents are left as is
// a result waits in the output register; a new input beat is taken meanwhile,
// the next result is held back until the output register is free
module positional_sequence_store (
  input  logic       clk,
  input  logic       rst_n,
  pss_in_if.sink     in_ch,
  pss_out_if.source  out_ch
);
  import pss_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FIN} state_t;

  state_t state_r, state_nxt;
  logic [MODE_W-1:0]     op_r, op_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [ITEM_WIDTH-1:0] val_r, val_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  okq_r, okq_nxt;
  logic [CNT_W-1:0]      rp_r, rp_nxt;
  logic [CNT_W-1:0]      rleft_r, rleft_nxt;
  logic                  rvld_r, rvld_nxt;
  logic [IDX_W-1:0]      rtag_r, rtag_nxt;
  logic [CNT_W-1:0]      wp_r, wp_nxt;
  logic                  hit_r, hit_nxt;
  logic [IDX_W-1:0]      hidx_r, hidx_nxt;
  logic [ITEM_WIDTH-1:0] carry_r, carry_nxt;

  logic                  ov_r, ov_nxt;
  logic                  ook_r, ook_nxt;
  logic [VAL_W-1:0]      ord_r, ord_nxt;
  logic [FIDX_W-1:0]     ofidx_r, ofidx_nxt;
  logic [RCNT_W-1:0]     orcnt_r, orcnt_nxt;
  logic [ICNT_W-1:0]     ocnt_r, ocnt_nxt;

  logic [ITEM_WIDTH-1:0] slots_mem [DEPTH];
  logic [ITEM_WIDTH-1:0] rdat_r;
  logic                  mem_we, mem_re;
  logic [IDX_W-1:0]      mem_waddr, mem_raddr;
  logic [ITEM_WIDTH-1:0] mem_wdata;
  logic                  drop;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  assign in_ch.ready          = (state_r == ST_IDLE);
  assign out_ch.valid         = ov_r;
  assign out_ch.ok            = ook_r;
  assign out_ch.read_item     = ord_r;
  assign out_ch.found_index   = ofidx_r;
  assign out_ch.removed_count = orcnt_r;
  assign out_ch.item_count    = ocnt_r;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    pos_nxt   = pos_r;
    val_nxt   = val_r;
    cnt_nxt   = cnt_r;
    okq_nxt   = okq_r;
    rp_nxt    = rp_r;
    rleft_nxt = rleft_r;
    rvld_nxt  = 1'b0;
    rtag_nxt  = rtag_r;
    wp_nxt    = wp_r;
    hit_nxt   = hit_r;
    hidx_nxt  = hidx_r;
    carry_nxt = carry_r;
    ov_nxt    = ov_r;
    ook_nxt   = ook_r;
    ord_nxt   = ord_r;
    ofidx_nxt = ofidx_r;
    orcnt_nxt = orcnt_r;
    ocnt_nxt  = ocnt_r;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    drop      = 1'b0;

    if (ov_r && out_ch.ready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          op_nxt    = in_ch.mode;
          pos_nxt   = in_ch.position;
          val_nxt   = in_ch.item_value[ITEM_WIDTH-1:0];
          hit_nxt   = 1'b0;
          hidx_nxt  = '0;
          rp_nxt    = '0;
          rleft_nxt = '0;
          wp_nxt    = '0;
          okq_nxt   = 1'b0;
          state_nxt = ST_RUN;
          case (in_ch.mode)
            MODE_INSERT_AT: begin
              if (in_ch.position <= cnt_r && cnt_r < DEPTH_C) begin
                okq_nxt   = 1'b1;
                rp_nxt    = in_ch.position;
                rleft_nxt = cnt_r - in_ch.position;
              end
            end
            MODE_SORTED_INSERT: begin
              if (cnt_r < DEPTH_C) begin
                okq_nxt   = 1'b1;
                rleft_nxt = cnt_r;
              end
            end
            MODE_ERASE_AT: begin
              if (in_ch.position < cnt_r) begin
                okq_nxt   = 1'b1;
                rp_nxt    = in_ch.position;
                wp_nxt    = in_ch.position;
                rleft_nxt = cnt_r - in_ch.position;
              end
            end
            MODE_REMOVE_ALL: begin
              okq_nxt   = 1'b1;
              rleft_nxt = cnt_r;
            end
            MODE_GET: begin
              if (in_ch.position < cnt_r) begin
                okq_nxt   = 1'b1;
                rp_nxt    = in_ch.position;
                rleft_nxt = CNT_W'(1);
              end
            end
            MODE_SET: begin
              okq_nxt = (in_ch.position < cnt_r);
            end
            MODE_FIND: begin
              okq_nxt   = 1'b1;
              rleft_nxt = cnt_r;
            end
            default: ;
          endcase
        end
      end

      ST_RUN: begin
        // issue one slot read per cycle, handle the slot read last cycle
        if (rleft_r != '0) begin
          mem_re    = 1'b1;
          mem_raddr = rp_r[IDX_W-1:0];
          rp_nxt    = rp_r + CNT_W'(1);
          rleft_nxt = rleft_r - CNT_W'(1);
          rvld_nxt  = 1'b1;
          rtag_nxt  = rp_r[IDX_W-1:0];
        end
        if (rvld_r) begin
          case (op_r)
            MODE_INSERT_AT, MODE_SORTED_INSERT: begin
              // after the insertion point every slot moves up by one
              if (hit_r) begin
                mem_we    = 1'b1;
                mem_waddr = rtag_r;
                mem_wdata = carry_r;
                carry_nxt = rdat_r;
              end else if (op_r == MODE_INSERT_AT || val_r <= rdat_r) begin
                mem_we    = 1'b1;
                mem_waddr = rtag_r;
                mem_wdata = val_r;
                carry_nxt = rdat_r;
                hit_nxt   = 1'b1;
              end
            end
            MODE_ERASE_AT, MODE_REMOVE_ALL: begin
              // compact: kept slots are written back at the write pointer
              drop = (op_r == MODE_ERASE_AT) ? (rtag_r == pos_r[IDX_W-1:0])
                                             : (rdat_r == val_r);
              if (!drop) begin
                mem_we    = 1'b1;
                mem_waddr = wp_r[IDX_W-1:0];
                mem_wdata = rdat_r;
                wp_nxt    = wp_r + CNT_W'(1);
              end
            end
            MODE_GET: begin
              carry_nxt = rdat_r;
            end
            MODE_FIND: begin
              if (!hit_r && rdat_r == val_r) begin
                hit_nxt  = 1'b1;
                hidx_nxt = rtag_r;
              end
            end
            default: ;
          endcase
        end
        if (rleft_r == '0 && !rvld_r) begin
          state_nxt = ST_FIN;
        end
      end

      ST_FIN: begin
        if (!ov_r || out_ch.ready) begin
          state_nxt = ST_IDLE;
          ov_nxt    = 1'b1;
          ook_nxt   = okq_r;
          ord_nxt   = '0;
          ofidx_nxt = '0;
          orcnt_nxt = '0;
          if (okq_r) begin
            case (op_r)
              MODE_INSERT_AT, MODE_SORTED_INSERT: begin
                mem_we    = 1'b1;
                mem_waddr = cnt_r[IDX_W-1:0];
                mem_wdata = hit_r ? carry_r : val_r;
                cnt_nxt   = cnt_r + CNT_W'(1);
              end
              MODE_ERASE_AT: begin
                cnt_nxt = wp_r;
              end
              MODE_REMOVE_ALL: begin
                cnt_nxt   = wp_r;
                orcnt_nxt = RCNT_W'(cnt_r - wp_r);
              end
              MODE_GET: begin
                ord_nxt = VAL_W'(carry_r);
              end
              MODE_SET: begin
                mem_we    = 1'b1;
                mem_waddr = pos_r[IDX_W-1:0];
                mem_wdata = val_r;
              end
              MODE_FIND: begin
                ook_nxt   = hit_r;
                ofidx_nxt = FIDX_W'(hidx_r);
              end
              default: ;
            endcase
          end
          ocnt_nxt = ICNT_W'(cnt_nxt);
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slots_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdat_r <= slots_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    pos_r   <= pos_nxt;
    val_r   <= val_nxt;
    okq_r   <= okq_nxt;
    rp_r    <= rp_nxt;
    rtag_r  <= rtag_nxt;
    wp_r    <= wp_nxt;
    hit_r   <= hit_nxt;
    hidx_r  <= hidx_nxt;
    carry_r <= carry_nxt;
    ook_r   <= ook_nxt;
    ord_r   <= ord_nxt;
    ofidx_r <= ofidx_nxt;
    orcnt_r <= orcnt_nxt;
    ocnt_r  <= ocnt_nxt;
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      rleft_r <= '0;
      rvld_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rleft_r <= rleft_nxt;
      rvld_r  <= rvld_nxt;
      ov_r    <= ov_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("held count above depth");

  a_beat_tag: assert property (@(posedge clk) disable iff (!rst_n)
    rvld_r |-> ({1'b0, rtag_r} < cnt_r))
    else $error("slot read beyond held items");

  a_wp_behind: assert property (@(posedge clk) disable iff (!rst_n)
    (rvld_r && (op_r == MODE_ERASE_AT || op_r == MODE_REMOVE_ALL))
      |-> (wp_r <= {1'b0, rtag_r}))
    else $error("compaction write pointer passed read pointer");

  a_load_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(state_r == ST_FIN))
    else $error("result loaded outside final step");

endmodule
